@@ rtl/vrp_pkg.sv @@
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared widths, constants, register indexes and the command and status
// words that join the voxel ray picker's controller and datapath.
// ----------------------------------------------------------------------------
package vrp_pkg;

    // Grid geometry and number format.
    localparam int GRID_EDGE       = 32;
    localparam int CW              = $clog2(GRID_EDGE);
    localparam int AW              = 3 * CW;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_SAMPLES_DEF = 500;
    localparam int DIR_EPS         = (1 << FRAC_BITS) / 10000;
    localparam int HALF_STEP       = 1 << (FRAC_BITS - 1);

    // Field widths.
    localparam int MAT_W   = 8;
    localparam int POS_W   = 32;
    localparam int DIR_W   = 18;
    localparam int SIZE_W  = 6;
    localparam int SCALE_W = 31;
    localparam int DIST_W  = 31;

    // Derived datapath widths.
    localparam int EXT_W      = SIZE_W + SCALE_W;          // size * scale
    localparam int BND_W      = EXT_W + 2;                 // doubled box bounds
    localparam int DIV_NUM_W  = BND_W - 1 + FRAC_BITS;     // slab numerator magnitude
    localparam int DIV_DEN_W  = SCALE_W + 1;               // twice the voxel scale
    localparam int DIV_SH_W   = DIR_W + DIV_NUM_W - 1;     // aligned divisor
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
    localparam int SLAB_ITERS = DIV_NUM_W;
    localparam int CELL_ITERS = CW;
    localparam int T_W        = DIV_NUM_W + 2;             // signed ray parameter
    localparam int SAMP_T_W   = 32;
    localparam int PROD_W     = DIR_W + SAMP_T_W + 1;
    localparam int N_W        = BND_W + 1;

    localparam logic signed [T_W-1:0] T_INF = {2'b00, {(T_W-2){1'b1}}};

    // Stream words.
    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 3'd7;

    // Divider operand selection.
    typedef enum logic [1:0] {
        DIV_LO   = 2'd0,
        DIV_HI   = 2'd1,
        DIV_CELL = 2'd2
    } div_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     clr_step;
        logic     wr_voxel;
        logic     load_ray;
        logic     calc_bounds;
        logic     axis_clear;
        logic     axis_next;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_lo;
        logic     upd_slab;
        logic     init_samp;
        logic     mul;
        logic     ncalc;
        logic     cap_cell;
        logic     read_mem;
        logic     advance;
        logic     keep_prev;
        logic     set_hit;
        logic     out_load;
    } vrp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic dir_small;
        logic par_out;
        logic axis_last;
        logic div_done;
        logic slab_miss;
        logic samp_end;
        logic lane_inb;
        logic mem_nonzero;
        logic out_free;
    } vrp_status_t;

endpackage

@@ rtl/vrp_div.sv @@
// ----------------------------------------------------------------------------
// vrp_div
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
// The caller hands in the divisor already aligned to the top quotient bit.
// ----------------------------------------------------------------------------
module vrp_div
    import vrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_CNT_W-1:0] iters,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_SH_W-1:0]  divisor_aligned,
    output logic [DIV_NUM_W-1:0] quotient,
    output logic                 done
);

    logic [DIV_NUM_W-1:0] rem_reg;
    logic [DIV_SH_W-1:0]  dsh_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 fits;

    // The shifted divisor fits under the partial remainder.
    assign fits = DIV_SH_W'(rem_reg) >= dsh_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One subtract and compare per quotient bit.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsh_reg <= divisor_aligned;
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg[DIV_NUM_W-1:0];
            end
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ rtl/vrp_datapath.sv @@
// ----------------------------------------------------------------------------
// vrp_datapath
// Configuration registers, voxel memory, slab clipping arithmetic, sample
// lanes and the result register of the voxel ray picker.
// ----------------------------------------------------------------------------
module vrp_datapath
    import vrp_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vrp_cmd_t              cmd,
    output vrp_status_t           status,
    // Configuration writes.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input payload.
    input  logic [CW-1:0]         cell_x,
    input  logic [CW-1:0]         cell_y,
    input  logic [CW-1:0]         cell_z,
    input  logic [MAT_W-1:0]      material,
    input  logic signed [POS_W-1:0] origin_x,
    input  logic signed [POS_W-1:0] origin_y,
    input  logic signed [POS_W-1:0] origin_z,
    input  logic signed [DIR_W-1:0] dir_x,
    input  logic signed [DIR_W-1:0] dir_y,
    input  logic signed [DIR_W-1:0] dir_z,
    // Result word.
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic                  hit,
    output logic [CW-1:0]         hit_x,
    output logic [CW-1:0]         hit_y,
    output logic [CW-1:0]         hit_z,
    output logic [CW-1:0]         place_x,
    output logic [CW-1:0]         place_y,
    output logic [CW-1:0]         place_z
);

    localparam int SC_W = $clog2(MAX_SAMPLES + 1);

    // Configuration registers.
    logic [SIZE_W-1:0]         size_reg [3];
    logic signed [POS_W-1:0]   ctr_reg  [3];
    logic [SCALE_W-1:0]        scale_reg;
    logic [DIST_W-1:0]         maxd_reg;

    // Ray and clipping registers.
    logic signed [POS_W-1:0]   org_reg    [3];
    logic signed [DIR_W-1:0]   dir_reg    [3];
    logic [EXT_W-1:0]          ext2_reg   [3];
    logic signed [BND_W-1:0]   lower2_reg [3];
    logic signed [BND_W-1:0]   upper2_reg [3];
    logic [1:0]                axis_reg;
    logic signed [T_W-1:0]     t1_reg;
    logic signed [T_W-1:0]     tmin_reg;
    logic signed [T_W-1:0]     tmax_reg;
    logic signed [T_W-1:0]     endt_reg;
    logic                      q_neg_reg;

    // Sampling registers.
    logic [SAMP_T_W-1:0]       t_reg;
    logic [SC_W-1:0]           samp_cnt_reg;
    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [N_W-1:0]     n_reg    [3];
    logic [CW-1:0]             c_reg    [3];
    logic [CW-1:0]             prev_reg [3];
    logic                      has_prev_reg;
    logic                      hit_reg;
    logic [MAT_W-1:0]          rd_data_reg;

    // Clearing pass.
    logic [AW-1:0]             clr_addr_reg;
    logic                      clr_done_reg;

    // Result register.
    logic                      m_valid_reg;
    logic                      hit_out_reg;
    logic [CW-1:0]             hit_out_reg_c   [3];
    logic [CW-1:0]             place_out_reg_c [3];

    // Voxel memory.
    logic [MAT_W-1:0]          mem [GRID_EDGE*GRID_EDGE*GRID_EDGE];

    // Effective configuration.
    logic [SIZE_W-1:0]         eff_size [3];
    logic [SCALE_W-1:0]        scale_eff;
    logic signed [T_W-1:0]     maxd_s;

    // Current axis views.
    logic signed [DIR_W-1:0]   cur_dir;
    logic [DIR_W-1:0]          cur_absd;
    logic signed [BND_W-1:0]   cur_o2;
    logic signed [BND_W-1:0]   cur_bnd;
    logic signed [BND_W-1:0]   cur_diff;
    logic [BND_W-2:0]          cur_mag;
    logic                      lane_inb [3];
    logic signed [N_W-1:0]     n_next   [3];

    // Divider hookup.
    logic [DIV_CNT_W-1:0]      div_iters;
    logic [DIV_NUM_W-1:0]      div_dividend;
    logic [DIV_SH_W-1:0]       div_dsh;
    logic [DIV_NUM_W-1:0]      div_q;
    logic                      div_done;
    logic signed [T_W-1:0]     t_slab;
    logic signed [T_W-1:0]     t_near;
    logic signed [T_W-1:0]     t_far;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            eff_size[a] = (size_reg[a] > SIZE_W'(GRID_EDGE)) ? SIZE_W'(GRID_EDGE)
                                                           : size_reg[a];
        end
    end
    assign scale_eff = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
    assign maxd_s    = $signed(T_W'(maxd_reg));

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                size_reg[a] <= SIZE_W'(GRID_EDGE);
                ctr_reg[a]  <= '0;
            end
            scale_reg <= SCALE_W'(1 << FRAC_BITS);
            maxd_reg  <= DIST_W'(200 << FRAC_BITS);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SIZE_X:   size_reg[0] <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:   size_reg[1] <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:   size_reg[2] <= cfg_data[SIZE_W-1:0];
                REG_CENTER_X: ctr_reg[0]  <= $signed(cfg_data[POS_W-1:0]);
                REG_CENTER_Y: ctr_reg[1]  <= $signed(cfg_data[POS_W-1:0]);
                REG_CENTER_Z: ctr_reg[2]  <= $signed(cfg_data[POS_W-1:0]);
                REG_SCALE:    scale_reg   <= cfg_data[SCALE_W-1:0];
                REG_MAX_DIST: maxd_reg    <= cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clearing pass over the voxel memory after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {AW{1'b1}}) begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // Voxel memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            mem[clr_addr_reg] <= '0;
        end else if (cmd.wr_voxel) begin
            mem[{cell_x, cell_y, cell_z}] <= material;
        end
        if (cmd.read_mem) begin
            rd_data_reg <= mem[{c_reg[0], c_reg[1], c_reg[2]}];
        end
    end

    // Current axis operands for the slab test.
    always_comb begin
        cur_dir  = dir_reg[axis_reg];
        cur_absd = cur_dir[DIR_W-1] ? DIR_W'(-cur_dir) : DIR_W'(cur_dir);
        cur_o2   = BND_W'(org_reg[axis_reg]) <<< 1;
        if (cmd.div_sel == DIV_HI) begin
            cur_bnd = (upper2_reg[axis_reg] + BND_W'(1)) >>> 1;
        end else begin
            cur_bnd = lower2_reg[axis_reg] >>> 1;
        end
        cur_diff = cur_bnd - BND_W'(org_reg[axis_reg]);
        cur_mag  = cur_diff[BND_W-1] ? cur_diff[BND_W-2:0] ^ '1 : cur_diff[BND_W-2:0];
        if (cur_diff[BND_W-1]) begin
            cur_mag = cur_mag + 1'b1;
        end
    end

    // Divider operands.
    always_comb begin
        if (cmd.div_sel == DIV_CELL) begin
            div_iters    = DIV_CNT_W'(CELL_ITERS);
            div_dividend = DIV_NUM_W'(unsigned'(n_reg[axis_reg]));
            div_dsh      = DIV_SH_W'({scale_eff, 1'b0}) << (CELL_ITERS - 1);
        end else begin
            div_iters    = DIV_CNT_W'(SLAB_ITERS);
            div_dividend = {cur_mag, {FRAC_BITS{1'b0}}};
            div_dsh      = DIV_SH_W'(cur_absd) << (SLAB_ITERS - 1);
        end
    end

    vrp_div u_div (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (cmd.div_start),
        .iters           (div_iters),
        .dividend        (div_dividend),
        .divisor_aligned (div_dsh),
        .quotient        (div_q),
        .done            (div_done)
    );

    // Signed slab parameter, truncated toward zero.
    always_comb begin
        t_slab = $signed({2'b00, div_q});
        if (q_neg_reg) begin
            t_slab = -t_slab;
        end
        t_near = (t1_reg < t_slab) ? t1_reg : t_slab;
        t_far  = (t1_reg < t_slab) ? t_slab : t1_reg;
    end

    // Sample lanes: point, doubled cell numerator, bounds test.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_next[a] = N_W'(org_reg[a]) + N_W'(prod_reg[a] >>> FRAC_BITS);
            n_next[a] = ((n_next[a] - N_W'(ctr_reg[a])) <<< 1) + $signed(N_W'(ext2_reg[a]));
            lane_inb[a] = !n_reg[a][N_W-1] &&
                          (n_reg[a] < $signed(N_W'({ext2_reg[a], 1'b0})));
        end
    end

    // Ray load, clipping and sampling state.
    always_ff @(posedge aclk) begin
        if (cmd.load_ray) begin
            org_reg[0] <= origin_x;
            org_reg[1] <= origin_y;
            org_reg[2] <= origin_z;
            dir_reg[0] <= dir_x;
            dir_reg[1] <= dir_y;
            dir_reg[2] <= dir_z;
            for (int a = 0; a < 3; a++) begin
                ext2_reg[a] <= EXT_W'(eff_size[a]) * EXT_W'(scale_eff);
            end
            tmin_reg <= -T_INF;
            tmax_reg <= T_INF;
        end
        if (cmd.calc_bounds) begin
            for (int a = 0; a < 3; a++) begin
                lower2_reg[a] <= (BND_W'(ctr_reg[a]) <<< 1) - $signed(BND_W'(ext2_reg[a]));
                upper2_reg[a] <= (BND_W'(ctr_reg[a]) <<< 1) + $signed(BND_W'(ext2_reg[a]));
            end
        end
        if (cmd.div_start && cmd.div_sel != DIV_CELL) begin
            q_neg_reg <= cur_diff[BND_W-1] ^ cur_dir[DIR_W-1];
        end
        if (cmd.cap_lo) begin
            t1_reg <= t_slab;
        end
        if (cmd.upd_slab) begin
            if (t_near > tmin_reg) begin
                tmin_reg <= t_near;
            end
            if (t_far < tmax_reg) begin
                tmax_reg <= t_far;
            end
        end
        if (cmd.init_samp) begin
            t_reg    <= (tmin_reg > 0) ? tmin_reg[SAMP_T_W-1:0] : '0;
            endt_reg <= (tmax_reg < maxd_s) ? tmax_reg : maxd_s;
        end else if (cmd.advance) begin
            t_reg <= t_reg + SAMP_T_W'(HALF_STEP);
        end
        if (cmd.mul) begin
            for (int a = 0; a < 3; a++) begin
                prod_reg[a] <= PROD_W'(dir_reg[a]) * $signed(PROD_W'({1'b0, t_reg}));
            end
        end
        if (cmd.ncalc) begin
            for (int a = 0; a < 3; a++) begin
                n_reg[a] <= n_next[a];
            end
        end
        if (cmd.cap_cell) begin
            c_reg[axis_reg] <= div_q[CW-1:0];
        end
        if (cmd.advance && cmd.keep_prev) begin
            for (int a = 0; a < 3; a++) begin
                prev_reg[a] <= c_reg[a];
            end
        end
    end

    // Control flags of the cast.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg     <= '0;
            samp_cnt_reg <= '0;
            has_prev_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            if (cmd.axis_clear) begin
                axis_reg <= '0;
            end else if (cmd.axis_next) begin
                axis_reg <= axis_reg + 1'b1;
            end
            if (cmd.load_ray) begin
                hit_reg <= 1'b0;
            end else if (cmd.set_hit) begin
                hit_reg <= 1'b1;
            end
            if (cmd.init_samp) begin
                samp_cnt_reg <= '0;
                has_prev_reg <= 1'b0;
            end else if (cmd.advance) begin
                samp_cnt_reg <= samp_cnt_reg + 1'b1;
                if (cmd.keep_prev) begin
                    has_prev_reg <= 1'b1;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            hit_out_reg <= hit_reg;
            for (int a = 0; a < 3; a++) begin
                hit_out_reg_c[a]   <= hit_reg ? c_reg[a] : '0;
                place_out_reg_c[a] <= !hit_reg ? '0 : (has_prev_reg ? prev_reg[a] : c_reg[a]);
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign hit     = hit_out_reg;
    assign hit_x   = hit_out_reg_c[0];
    assign hit_y   = hit_out_reg_c[1];
    assign hit_z   = hit_out_reg_c[2];
    assign place_x = place_out_reg_c[0];
    assign place_y = place_out_reg_c[1];
    assign place_z = place_out_reg_c[2];

    // Status back to the controller.
    always_comb begin
        status.clr_done    = clr_done_reg;
        status.dir_small   = (cur_dir >= -DIR_W'(DIR_EPS)) && (cur_dir <= DIR_W'(DIR_EPS));
        status.par_out     = (cur_o2 < lower2_reg[axis_reg]) || (cur_o2 > upper2_reg[axis_reg]);
        status.axis_last   = (axis_reg == 2'd2);
        status.div_done    = div_done;
        status.slab_miss   = (tmin_reg > tmax_reg) || (tmin_reg > maxd_s);
        status.samp_end    = (samp_cnt_reg == SC_W'(MAX_SAMPLES)) ||
                             ($signed(T_W'(t_reg)) > endt_reg);
        status.lane_inb    = lane_inb[axis_reg];
        status.mem_nonzero = (rd_data_reg != '0);
        status.out_free    = !m_valid_reg || m_ready;
    end

endmodule

@@ rtl/vrp_ctrl.sv @@
// ----------------------------------------------------------------------------
// vrp_ctrl
// Sequencer of the voxel ray picker: clearing pass, voxel writes, slab
// clipping per axis, and the sample loop with its memory lookups.
// ----------------------------------------------------------------------------
module vrp_ctrl
    import vrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_cast,
    output logic        s_ready,
    input  vrp_status_t status,
    output vrp_cmd_t    cmd
);

    typedef enum logic [13:0] {
        ST_CLEAR = 14'b00000000000001,
        ST_IDLE  = 14'b00000000000010,
        ST_BOUND = 14'b00000000000100,
        ST_AXIS  = 14'b00000000001000,
        ST_DLO   = 14'b00000000010000,
        ST_DHI   = 14'b00000000100000,
        ST_CHECK = 14'b00000001000000,
        ST_SAMP  = 14'b00000010000000,
        ST_NCALC = 14'b00000100000000,
        ST_CELL  = 14'b00001000000000,
        ST_CDIV  = 14'b00010000000000,
        ST_READ  = 14'b00100000000000,
        ST_TEST  = 14'b01000000000000,
        ST_FIN   = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_LO;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clr_done) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.clr_step = 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid && !s_cast) begin
                    cmd.wr_voxel = 1'b1;
                end else if (s_valid) begin
                    cmd.load_ray = 1'b1;
                    state_next   = ST_BOUND;
                end
            end
            ST_BOUND: begin
                cmd.calc_bounds = 1'b1;
                cmd.axis_clear  = 1'b1;
                state_next      = ST_AXIS;
            end
            ST_AXIS: begin
                if (!status.dir_small) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DLO;
                end else if (status.par_out) begin
                    state_next = ST_FIN;
                end else if (status.axis_last) begin
                    state_next = ST_CHECK;
                end else begin
                    cmd.axis_next = 1'b1;
                end
            end
            ST_DLO: begin
                if (status.div_done) begin
                    cmd.cap_lo    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_HI;
                    state_next    = ST_DHI;
                end
            end
            ST_DHI: begin
                cmd.div_sel = DIV_HI;
                if (status.div_done) begin
                    cmd.upd_slab = 1'b1;
                    if (status.axis_last) begin
                        state_next = ST_CHECK;
                    end else begin
                        cmd.axis_next = 1'b1;
                        state_next    = ST_AXIS;
                    end
                end
            end
            ST_CHECK: begin
                if (status.slab_miss) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.init_samp = 1'b1;
                    state_next    = ST_SAMP;
                end
            end
            ST_SAMP: begin
                if (status.samp_end) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = ST_NCALC;
                end
            end
            ST_NCALC: begin
                cmd.ncalc      = 1'b1;
                cmd.axis_clear = 1'b1;
                state_next     = ST_CELL;
            end
            ST_CELL: begin
                cmd.div_sel = DIV_CELL;
                if (status.lane_inb) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_CDIV;
                end else begin
                    // Out of the grid: step on, keep the last empty cell.
                    cmd.advance = 1'b1;
                    state_next  = ST_SAMP;
                end
            end
            ST_CDIV: begin
                cmd.div_sel = DIV_CELL;
                if (status.div_done) begin
                    cmd.cap_cell = 1'b1;
                    if (status.axis_last) begin
                        state_next = ST_READ;
                    end else begin
                        cmd.axis_next = 1'b1;
                        state_next    = ST_CELL;
                    end
                end
            end
            ST_READ: begin
                cmd.read_mem = 1'b1;
                state_next   = ST_TEST;
            end
            ST_TEST: begin
                if (status.mem_nonzero) begin
                    cmd.set_hit = 1'b1;
                    state_next  = ST_FIN;
                end else begin
                    cmd.advance   = 1'b1;
                    cmd.keep_prev = 1'b1;
                    state_next    = ST_SAMP;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/voxel_ray_pick.sv @@
// ----------------------------------------------------------------------------
// voxel_ray_pick
// Voxel grid store with a ray picker: writes voxels and casts rays that
// report the first solid voxel and the last empty voxel in front of it.
// ----------------------------------------------------------------------------
// After reset the block zeroes its 32768-entry voxel memory, one entry per
// cycle, and takes no input word until the pass ends (configuration writes
// are taken at any time). A write word is stored straight from the idle
// state. A cast runs two slab divisions on a one-bit-per-cycle divider for
// each axis whose direction is not near zero, then for each sample the point
// multiply and cell numerator, a cell division per axis when the point lies
// in the grid, and the memory read, for up to MAX_SAMPLES samples (default
// 500). The result word is registered; the next input word is taken while a
// result still waits on the master side.
module voxel_ray_pick
    import vrp_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input words.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // cell_x, cell_y, cell_z, material, origin_x, origin_y, origin_z,
    // dir_x, dir_y, dir_z, zero fill
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // command
    input  logic                   s_axis_tuser,
    // Result words.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // hit_x, hit_y, hit_z, place_x, place_y, place_z, zero fill
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // hit
    output logic                   m_axis_tuser,
    // Configuration writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    vrp_cmd_t    cmd;
    vrp_status_t status;
    logic        hit;
    logic [CW-1:0] hit_x, hit_y, hit_z, place_x, place_y, place_z;

    assign cfg_ready = 1'b1;

    vrp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_cast  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    vrp_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_x    (s_axis_tdata[4:0]),
        .cell_y    (s_axis_tdata[9:5]),
        .cell_z    (s_axis_tdata[14:10]),
        .material  (s_axis_tdata[22:15]),
        .origin_x  ($signed(s_axis_tdata[54:23])),
        .origin_y  ($signed(s_axis_tdata[86:55])),
        .origin_z  ($signed(s_axis_tdata[118:87])),
        .dir_x     ($signed(s_axis_tdata[136:119])),
        .dir_y     ($signed(s_axis_tdata[154:137])),
        .dir_z     ($signed(s_axis_tdata[172:155])),
        .m_ready   (m_axis_tready),
        .m_valid   (m_axis_tvalid),
        .hit       (hit),
        .hit_x     (hit_x),
        .hit_y     (hit_y),
        .hit_z     (hit_z),
        .place_x   (place_x),
        .place_y   (place_y),
        .place_z   (place_z)
    );

    assign m_axis_tdata = {2'b00, place_z, place_y, place_x, hit_z, hit_y, hit_x};
    assign m_axis_tuser = hit;

    // The clearing pass keeps the input side closed right after reset.
    a_clear_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready)
        else $error("input word taken during the clearing pass");

    // A miss carries no coordinates.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("miss word with nonzero coordinates");

    // A cast occupies the block for at least the next cycle.
    a_cast_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
        else $error("input taken right after a cast");

endmodule
